// ----- hw/rtl/stcmap_pkg.sv -----
package stcmap_pkg;

  // Fixed-point formats.
  localparam int FRAC_W  = 16;
  localparam int COLOR_W = FRAC_W + 1;
  localparam int WL_W    = 26;

  typedef logic [COLOR_W-1:0] color_t;

  // One RGBA result, red in the lowest bits.
  typedef struct packed {
    color_t alpha;
    color_t blue;
    color_t green;
    color_t red;
  } rgba_t;

  localparam color_t ONE = color_t'(1 << FRAC_W);

  // Pipeline depths.
  localparam int QUOT_W       = FRAC_W;
  localparam int NORM_STAGES  = 2 + QUOT_W;
  localparam int SQRT_STEPS   = FRAC_W + 1;
  localparam int SHADE_STAGES = 3 + SQRT_STEPS + 4;
  localparam int PIPE_STAGES  = NORM_STAGES + SHADE_STAGES;

  // Register map, indexed by word address.
  localparam logic [1:0] REG_RANGE_MIN    = 2'd0;
  localparam logic [1:0] REG_RANGE_MAX    = 2'd1;
  localparam logic [1:0] REG_COLOR_SCHEME = 2'd2;

  localparam logic [1:0] SCHEME_GRAY = 2'd2;

  // Wavelength breakpoints in Q10.16.
  localparam logic [WL_W-1:0] WL_BASE = WL_W'(420 << FRAC_W);
  localparam logic [WL_W-1:0] WL_439  = WL_W'(439 << FRAC_W);
  localparam logic [WL_W-1:0] WL_440  = WL_W'(440 << FRAC_W);
  localparam logic [WL_W-1:0] WL_489  = WL_W'(489 << FRAC_W);
  localparam logic [WL_W-1:0] WL_509  = WL_W'(509 << FRAC_W);
  localparam logic [WL_W-1:0] WL_510  = WL_W'(510 << FRAC_W);
  localparam logic [WL_W-1:0] WL_579  = WL_W'(579 << FRAC_W);
  localparam logic [WL_W-1:0] WL_644  = WL_W'(644 << FRAC_W);
  localparam logic [WL_W-1:0] WL_645  = WL_W'(645 << FRAC_W);

  // Spectrum segments.
  localparam logic [2:0] SEG_VIOLET = 3'd0;
  localparam logic [2:0] SEG_CYAN   = 3'd1;
  localparam logic [2:0] SEG_GREEN  = 3'd2;
  localparam logic [2:0] SEG_YELLOW = 3'd3;
  localparam logic [2:0] SEG_ORANGE = 3'd4;
  localparam logic [2:0] SEG_RED    = 3'd5;

  localparam int DEN_VIOLET = 440 - 350;
  localparam int DEN_CYAN   = 490 - 440;
  localparam int DEN_GREEN  = 510 - 490;
  localparam int DEN_YELLOW = 580 - 510;
  localparam int DEN_ORANGE = 645 - 580;

  localparam logic [31:0] RECIP_VIOLET = 32'(64'd4294967296 / 64'(DEN_VIOLET));
  localparam logic [31:0] RECIP_CYAN   = 32'(64'd4294967296 / 64'(DEN_CYAN));
  localparam logic [31:0] RECIP_GREEN  = 32'(64'd4294967296 / 64'(DEN_GREEN));
  localparam logic [31:0] RECIP_YELLOW = 32'(64'd4294967296 / 64'(DEN_YELLOW));
  localparam logic [31:0] RECIP_ORANGE = 32'(64'd4294967296 / 64'(DEN_ORANGE));

  function automatic logic [6:0] seg_den(input logic [2:0] seg);
    case (seg)
      SEG_VIOLET: seg_den = 7'(DEN_VIOLET);
      SEG_CYAN:   seg_den = 7'(DEN_CYAN);
      SEG_GREEN:  seg_den = 7'(DEN_GREEN);
      SEG_YELLOW: seg_den = 7'(DEN_YELLOW);
      SEG_ORANGE: seg_den = 7'(DEN_ORANGE);
      default:    seg_den = 7'd1;
    endcase
  endfunction

  function automatic logic [31:0] seg_recip(input logic [2:0] seg);
    case (seg)
      SEG_VIOLET: seg_recip = RECIP_VIOLET;
      SEG_CYAN:   seg_recip = RECIP_CYAN;
      SEG_GREEN:  seg_recip = RECIP_GREEN;
      SEG_YELLOW: seg_recip = RECIP_YELLOW;
      SEG_ORANGE: seg_recip = RECIP_ORANGE;
      default:    seg_recip = 32'd0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/stcmap_norm.sv -----
module stcmap_norm (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [31:0]    sample,
  input  logic signed [31:0]    range_min,
  input  logic signed [31:0]    range_max,
  output stcmap_pkg::color_t    t
);

  localparam int QW = stcmap_pkg::QUOT_W;

  logic signed [32:0] diff;
  logic signed [32:0] span;

  logic [31:0]   rem  [QW+1];
  logic [31:0]   den  [QW+1];
  logic [QW-1:0] quo  [QW+1];
  logic          zero [QW+1];
  logic          full [QW+1];

  logic [32:0]   shl      [QW];
  logic          take     [QW];
  logic [31:0]   rem_next [QW];

  // One quotient bit per stage by restoring division.
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      shl[k]      = {rem[k], 1'b0};
      take[k]     = shl[k] >= {1'b0, den[k]};
      rem_next[k] = take[k] ? 32'(shl[k] - {1'b0, den[k]}) : shl[k][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff    <= {sample[31], sample} - {range_min[31], range_min};
      span    <= {range_max[31], range_max} - {range_min[31], range_min};
      zero[0] <= (span <= 33'sd0) || (diff <= 33'sd0);
      full[0] <= diff >= span;
      rem[0]  <= diff[31:0];
      den[0]  <= span[31:0];
      quo[0]  <= '0;
      for (int k = 0; k < QW; k++) begin
        rem[k+1]  <= rem_next[k];
        den[k+1]  <= den[k];
        quo[k+1]  <= {quo[k][QW-2:0], take[k]};
        zero[k+1] <= zero[k];
        full[k+1] <= full[k];
      end
    end
  end

  assign t = zero[QW] ? '0 :
             full[QW] ? stcmap_pkg::ONE : stcmap_pkg::color_t'(quo[QW]);

endmodule

// ----- hw/rtl/stcmap_shade.sv -----
module stcmap_shade (
  input  logic                clk,
  input  logic                en,
  input  stcmap_pkg::color_t  t,
  input  logic [1:0]          color_scheme,
  output stcmap_pkg::rgba_t   pix
);

  localparam int SN = stcmap_pkg::SQRT_STEPS;
  localparam int WW = stcmap_pkg::WL_W;

  // Cube of t for the grayscale alpha curve.
  logic [32:0]        t_sq;
  stcmap_pkg::color_t t_g1;
  logic [32:0]        cube_hi;
  stcmap_pkg::color_t t_g2;
  logic [49:0]        cube;

  // Square root, one result bit per stage.
  logic [32:0]        srem  [SN+1];
  logic [16:0]        sroot [SN+1];
  stcmap_pkg::color_t st    [SN+1];
  logic [35:0]        delta [SN];
  logic               sge   [SN];

  // Tail stages.
  logic signed [19:0]   a_raw;
  stcmap_pkg::color_t   a_gray;
  stcmap_pkg::color_t   a_x1, a_x2, a_x3;
  stcmap_pkg::color_t   t_x1, t_x2, t_x3;
  logic [WW-1:0]        wl;
  logic [2:0]           seg, seg_x2, seg_x3;
  logic signed [26:0]   num_raw;
  logic [22:0]          num, num_x2, num_x3;
  logic [54:0]          prod;
  logic [18:0]          q0_x3;
  logic [25:0]          chk;
  logic [25:0]          rmd;
  logic [18:0]          quot;
  stcmap_pkg::color_t   ramp;
  stcmap_pkg::rgba_t    jet;

  assign cube = 50'(t_sq) * 50'(t_g1);

  always_comb begin
    for (int k = 0; k < SN; k++) begin
      delta[k] = (36'(sroot[k]) << (SN - k)) + (36'd1 << (2 * (SN - 1 - k)));
      sge[k]   = 36'(srem[k]) >= delta[k];
    end
  end

  assign a_raw  = $signed(20'({st[SN], 1'b0}) + 20'(st[SN]) - 20'({sroot[SN], 1'b0}));
  assign a_gray = a_raw[19] ? '0 :
                  (a_raw > 20'sd65536) ? stcmap_pkg::ONE : a_raw[16:0];

  // Pick the spectrum segment and the ramp numerator.
  always_comb begin
    priority if (wl <= stcmap_pkg::WL_439) begin
      seg     = stcmap_pkg::SEG_VIOLET;
      num_raw = $signed(27'(stcmap_pkg::WL_440) - 27'(wl));
    end else if (wl <= stcmap_pkg::WL_489) begin
      seg     = stcmap_pkg::SEG_CYAN;
      num_raw = $signed(27'(wl) - 27'(stcmap_pkg::WL_440));
    end else if (wl <= stcmap_pkg::WL_509) begin
      seg     = stcmap_pkg::SEG_GREEN;
      num_raw = $signed(27'(stcmap_pkg::WL_510) - 27'(wl));
    end else if (wl <= stcmap_pkg::WL_579) begin
      seg     = stcmap_pkg::SEG_YELLOW;
      num_raw = $signed(27'(wl) - 27'(stcmap_pkg::WL_510));
    end else if (wl <= stcmap_pkg::WL_644) begin
      seg     = stcmap_pkg::SEG_ORANGE;
      num_raw = $signed(27'(stcmap_pkg::WL_645) - 27'(wl));
    end else begin
      seg     = stcmap_pkg::SEG_RED;
      num_raw = '0;
    end
    num = num_raw[26] ? '0 : num_raw[22:0];
  end

  // The reciprocal product is low by at most one; a single correction fixes it.
  assign prod = 55'(num_x2) * 55'(stcmap_pkg::seg_recip(seg_x2));
  assign chk  = 26'(q0_x3) * 26'(stcmap_pkg::seg_den(seg_x3));
  assign rmd  = 26'(num_x3) - chk;
  assign quot = q0_x3 + 19'(rmd >= 26'(stcmap_pkg::seg_den(seg_x3)));
  assign ramp = (quot[18:16] != 3'd0) ? stcmap_pkg::ONE : stcmap_pkg::color_t'(quot);

  always_comb begin
    jet.alpha = stcmap_pkg::ONE;
    case (seg_x3)
      stcmap_pkg::SEG_VIOLET: begin
        jet.red = ramp; jet.green = '0; jet.blue = stcmap_pkg::ONE;
      end
      stcmap_pkg::SEG_CYAN: begin
        jet.red = '0; jet.green = ramp; jet.blue = stcmap_pkg::ONE;
      end
      stcmap_pkg::SEG_GREEN: begin
        jet.red = '0; jet.green = stcmap_pkg::ONE; jet.blue = ramp;
      end
      stcmap_pkg::SEG_YELLOW: begin
        jet.red = ramp; jet.green = stcmap_pkg::ONE; jet.blue = '0;
      end
      stcmap_pkg::SEG_ORANGE: begin
        jet.red = stcmap_pkg::ONE; jet.green = ramp; jet.blue = '0;
      end
      default: begin
        jet.red = stcmap_pkg::ONE; jet.green = '0; jet.blue = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_sq     <= 33'(34'(t) * 34'(t));
      t_g1     <= t;
      cube_hi  <= cube[48:16];
      t_g2     <= t_g1;
      srem[0]  <= cube_hi;
      sroot[0] <= '0;
      st[0]    <= t_g2;
      for (int k = 0; k < SN; k++) begin
        srem[k+1]  <= sge[k] ? 33'(36'(srem[k]) - delta[k]) : srem[k];
        sroot[k+1] <= sge[k] ? (sroot[k] | (17'd1 << (SN - 1 - k))) : sroot[k];
        st[k+1]    <= st[k];
      end
      a_x1   <= a_gray;
      t_x1   <= st[SN];
      wl     <= stcmap_pkg::WL_BASE + WW'(st[SN]) * WW'(360);
      a_x2   <= a_x1;
      t_x2   <= t_x1;
      seg_x2 <= seg;
      num_x2 <= num;
      a_x3   <= a_x2;
      t_x3   <= t_x2;
      seg_x3 <= seg_x2;
      num_x3 <= num_x2;
      q0_x3  <= prod[50:32];
      if (color_scheme == stcmap_pkg::SCHEME_GRAY) begin
        pix.red   <= t_x3;
        pix.green <= t_x3;
        pix.blue  <= t_x3;
        pix.alpha <= a_x3;
      end else begin
        pix <= jet;
      end
    end
  end

endmodule

// ----- hw/rtl/scalar_to_rgba_colormap.sv -----
// Scalar to RGBA colour map.
// Each request on the slave stream carries one signed Q16.16 sample. The
// block normalises it against range_min and range_max to a fraction t in
// [0,1] and turns t into a colour: a spectrum ramp with opaque alpha for the
// jet scheme (any code but grayscale), or a grey level with alpha = 3t - 2t^1.5 for the
// grayscale scheme. Each result request on the master stream carries red,
// green, blue and alpha as unsigned Q1.16 values, where 65536 means 1.0.
// The three registers sit on the APB port at byte addresses 0, 4 and 8 and
// should only be written while no sample is in flight.
// The datapath is a 42-stage pipeline: sixteen stages of restoring division
// for the normalisation and seventeen stages of square root for the alpha
// curve set the depth. A result leaves the last stage into the output register,
// and one sample is accepted every cycle while the skid register is empty.
// Reset clears every valid bit and returns the registers to range 0 to 1.0
// with the jet scheme. When the receiver stalls, the output register holds
// its result and one further result is caught in a skid register; the whole
// pipeline then holds until the skid register drains, so nothing is lost.
module scalar_to_rgba_colormap (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [16:0] red, [33:17] green, [50:34] blue,
                                 // [67:51] alpha, [71:68] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NS = stcmap_pkg::PIPE_STAGES;

  logic signed [31:0] range_min;
  logic signed [31:0] range_max;
  logic [1:0]         color_scheme;

  logic               adv;
  logic [NS-1:0]      vld;
  stcmap_pkg::color_t t;
  stcmap_pkg::rgba_t  pix;
  stcmap_pkg::rgba_t  out_pix;
  stcmap_pkg::rgba_t  skid_pix;
  logic               out_vld;
  logic               skid_vld;

  // Configuration registers. Writes complete in the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min    <= '0;
      range_max    <= 32'sd65536;
      color_scheme <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        stcmap_pkg::REG_RANGE_MIN:    range_min    <= pwdata;
        stcmap_pkg::REG_RANGE_MAX:    range_max    <= pwdata;
        stcmap_pkg::REG_COLOR_SCHEME: color_scheme <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      stcmap_pkg::REG_RANGE_MIN:    prdata = range_min;
      stcmap_pkg::REG_RANGE_MAX:    prdata = range_max;
      stcmap_pkg::REG_COLOR_SCHEME: prdata = {30'd0, color_scheme};
      default:                      prdata = '0;
    endcase
  end

  // The pipeline moves as one whenever the skid register is free.
  assign adv      = !skid_vld;
  assign s_tready = adv;

  stcmap_norm u_norm (
    .clk       (clk),
    .en        (adv),
    .sample    (s_tdata),
    .range_min (range_min),
    .range_max (range_max),
    .t         (t)
  );

  stcmap_shade u_shade (
    .clk          (clk),
    .en           (adv),
    .t            (t),
    .color_scheme (color_scheme),
    .pix          (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (adv) begin
        vld <= {vld[NS-2:0], s_tvalid};
      end
      if (skid_vld) begin
        if (m_tready) begin
          skid_vld <= 1'b0;
        end
      end else if (vld[NS-1]) begin
        if (out_vld && !m_tready) begin
          skid_vld <= 1'b1;
        end else begin
          out_vld <= 1'b1;
        end
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (m_tready) begin
        out_pix <= skid_pix;
      end
    end else if (vld[NS-1]) begin
      if (out_vld && !m_tready) begin
        skid_pix <= pix;
      end else begin
        out_pix <= pix;
      end
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {4'd0, out_pix};

endmodule

// ----- hw/rtl/stcmap_chk.sv -----
module stcmap_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_drain_opens: assert property (@(posedge clk) disable iff (rst)
    m_tready |=> s_tready)
    else $error("input still blocked after the receiver took a result");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[16:0] <= 17'd65536 && m_tdata[33:17] <= 17'd65536 &&
                  m_tdata[50:34] <= 17'd65536 && m_tdata[67:51] <= 17'd65536 &&
                  m_tdata[71:68] == 4'd0))
    else $error("colour component above 1.0 or padding not zero");

endmodule

bind scalar_to_rgba_colormap stcmap_chk u_chk (.*);
